### design/wrv_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// wrv_pkg
// Shared types and constants of the weighted running variance block.
// ---------------------------------------------------------------------------
package wrv_pkg;

    localparam int VALUE_W = 32;
    localparam int ACC_W   = 48;
    localparam int DEV_W   = 64;

    localparam logic FUNC_PUSH  = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    typedef struct packed {
        logic                      func;
        logic signed [VALUE_W-1:0] value;
        logic [VALUE_W-1:0]        sample_weight;
        logic [VALUE_W-1:0]        count_increment;
    } wrv_in_t;

    typedef struct packed {
        logic [ACC_W-1:0]          sample_count;
        logic [ACC_W-1:0]          total_weight;
        logic signed [VALUE_W-1:0] running_mean;
        logic [DEV_W-1:0]          squared_deviation_sum;
        logic [DEV_W-1:0]          variance;
        logic                      saturated;
    } wrv_out_t;

endpackage
`default_nettype wire

### design/wrv_in_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// wrv_in_if
// Valid/ready channel carrying one sample word.
// ---------------------------------------------------------------------------
interface wrv_in_if;
    logic             valid;
    logic             ready;
    wrv_pkg::wrv_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/wrv_out_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// wrv_out_if
// Valid/ready channel carrying one statistics word.
// ---------------------------------------------------------------------------
interface wrv_out_if;
    logic              valid;
    logic              ready;
    wrv_pkg::wrv_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/weighted_running_variance.sv
`default_nettype none
// ---------------------------------------------------------------------------
// weighted_running_variance
// Weighted Welford running mean and variance in fixed point.
// ---------------------------------------------------------------------------
// One word is processed at a time; the result is registered when the
// processing ends and becomes valid in the same cycle that the input is
// ready again. A clear word, or a push that leaves the total weight at zero,
// goes straight to the done state. A push runs a bit-serial multiply, a
// bit-serial divide for the mean step, a step that applies it, a second
// bit-serial multiply and, when the total weight exceeds one, a bit-serial
// divide for the variance. The single shift-and-add multiplier and the single
// restoring divider set the rate. A finished word waits in the output
// register while the next word is taken; a result not yet taken stalls the
// next word in its done state.
module weighted_running_variance (
    input  wire logic   clk,
    input  wire logic   rst_n,
    wrv_in_if.sink      samples,
    wrv_out_if.source   results
);
    import wrv_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL1 = 3'd1;
    localparam logic [2:0] ST_DIV1 = 3'd2;
    localparam logic [2:0] ST_MEAN = 3'd3;
    localparam logic [2:0] ST_MUL2 = 3'd4;
    localparam logic [2:0] ST_DIV2 = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    localparam int PROD_W = DEV_W + VALUE_W + 1;

    logic [2:0]                state_reg, state_next;
    logic [6:0]                step_reg, step_next;
    logic [ACC_W-1:0]          cnt_reg, cnt_next;
    logic [ACC_W-1:0]          wgt_reg, wgt_next;
    logic signed [VALUE_W-1:0] mean_reg, mean_next;
    logic [DEV_W-1:0]          dev_reg, dev_next;
    logic                      ovf_reg, ovf_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic                      neg_reg, neg_next;
    logic [DEV_W-1:0]          p_reg, p_next;
    logic [DEV_W-1:0]          var_reg, var_next;
    logic [PROD_W-1:0]         acc_reg, acc_next;
    logic [DEV_W-1:0]          mcand_reg, mcand_next;
    logic [VALUE_W-1:0]        mplier_reg, mplier_next;
    logic [DEV_W-1:0]          dvd_reg, dvd_next;
    logic [ACC_W-1:0]          rem_reg, rem_next;
    logic                      ovalid_reg, ovalid_next;
    wrv_out_t                  odata_reg, odata_next;

    logic                      accept;
    logic [ACC_W:0]            cnt_sum, wgt_sum;
    logic [ACC_W-1:0]          wgt_new;
    logic [VALUE_W:0]          diff1, diff2, nm;
    logic [VALUE_W-1:0]        mag1, mag2;
    logic [PROD_W-1:0]         acc_step;
    logic [ACC_W:0]            rem_sh, rem_sub;
    logic [DEV_W:0]            dev_sum;
    logic [DEV_W-1:0]          incr;
    logic                      incr_ovf;
    logic                      dev_sat;
    logic [DEV_W-1:0]          dev_new;

    assign samples.ready = (state_reg == ST_IDLE);
    assign accept        = samples.valid && samples.ready;
    assign results.valid = ovalid_reg;
    assign results.data  = odata_reg;

    // Shared datapath pieces
    always_comb
    begin
        cnt_sum  = {1'b0, cnt_reg}
                   + {{(ACC_W-VALUE_W+1){1'b0}}, samples.data.count_increment};
        wgt_sum  = {1'b0, wgt_reg}
                   + {{(ACC_W-VALUE_W+1){1'b0}}, samples.data.sample_weight};
        wgt_new  = wgt_sum[ACC_W] ? {ACC_W{1'b1}} : wgt_sum[ACC_W-1:0];
        diff1    = {samples.data.value[VALUE_W-1], samples.data.value}
                   - {mean_reg[VALUE_W-1], mean_reg};
        mag1     = diff1[VALUE_W] ? VALUE_W'(-diff1) : diff1[VALUE_W-1:0];
        acc_step = {acc_reg[PROD_W-2:0], 1'b0}
                   + (mplier_reg[VALUE_W-1] ? {{(PROD_W-DEV_W){1'b0}}, mcand_reg}
                                            : {PROD_W{1'b0}});
        rem_sh   = {rem_reg, dvd_reg[DEV_W-1]};
        rem_sub  = rem_sh - {1'b0, wgt_reg};
        nm       = neg_reg ? {mean_reg[VALUE_W-1], mean_reg} - {1'b0, dvd_reg[VALUE_W-1:0]}
                           : {mean_reg[VALUE_W-1], mean_reg} + {1'b0, dvd_reg[VALUE_W-1:0]};
        diff2    = {val_reg[VALUE_W-1], val_reg} - nm;
        mag2     = diff2[VALUE_W] ? VALUE_W'(-diff2) : diff2[VALUE_W-1:0];
        incr_ovf = (acc_step[PROD_W-1:DEV_W] != '0);
        incr     = incr_ovf ? {DEV_W{1'b1}} : acc_step[DEV_W-1:0];
        dev_sum  = {1'b0, dev_reg} + {1'b0, incr};
        dev_sat  = incr_ovf || dev_sum[DEV_W];
        dev_new  = dev_sat ? {DEV_W{1'b1}} : dev_sum[DEV_W-1:0];
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        cnt_next    = cnt_reg;
        wgt_next    = wgt_reg;
        mean_next   = mean_reg;
        dev_next    = dev_reg;
        ovf_next    = ovf_reg;
        val_next    = val_reg;
        neg_next    = neg_reg;
        p_next      = p_reg;
        var_next    = var_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;

        // drop the output word once taken
        if (ovalid_reg && results.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    var_next = '0;
                    if (samples.data.func == FUNC_CLEAR)
                    begin
                        cnt_next   = '0;
                        wgt_next   = '0;
                        mean_next  = '0;
                        dev_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cnt_next = cnt_sum[ACC_W] ? {ACC_W{1'b1}} : cnt_sum[ACC_W-1:0];
                        wgt_next = wgt_new;
                        if (cnt_sum[ACC_W] || wgt_sum[ACC_W])
                        begin
                            ovf_next = 1'b1;
                        end
                        val_next    = samples.data.value;
                        neg_next    = diff1[VALUE_W];
                        acc_next    = '0;
                        mcand_next  = {{(DEV_W-VALUE_W){1'b0}}, samples.data.sample_weight};
                        mplier_next = mag1;
                        step_next   = 7'(VALUE_W - 1);
                        state_next  = (wgt_new == '0) ? ST_DONE : ST_MUL1;
                    end
                end
            end
            ST_MUL1, ST_MUL2:
            begin
                acc_next    = acc_step;
                mplier_next = {mplier_reg[VALUE_W-2:0], 1'b0};
                step_next   = step_reg - 7'd1;
                if (step_reg == '0)
                begin
                    if (state_reg == ST_MUL1)
                    begin
                        // product weight * |value - mean|; divide by total weight
                        p_next     = acc_step[DEV_W-1:0];
                        dvd_next   = acc_step[DEV_W-1:0];
                        rem_next   = '0;
                        step_next  = 7'(DEV_W - 1);
                        state_next = ST_DIV1;
                    end
                    else
                    begin
                        // accumulate the weighted squared deviation
                        dev_next = dev_new;
                        if (dev_sat)
                        begin
                            ovf_next = 1'b1;
                        end
                        dvd_next   = dev_new;
                        rem_next   = '0;
                        step_next  = 7'(DEV_W - 1);
                        state_next = (wgt_reg > {{(ACC_W-1){1'b0}}, 1'b1}) ? ST_DIV2 : ST_DONE;
                    end
                end
            end
            ST_DIV1, ST_DIV2:
            begin
                rem_next  = rem_sub[ACC_W] ? rem_sh[ACC_W-1:0] : rem_sub[ACC_W-1:0];
                dvd_next  = {dvd_reg[DEV_W-2:0], ~rem_sub[ACC_W]};
                step_next = step_reg - 7'd1;
                if (step_reg == '0)
                begin
                    if (state_reg == ST_DIV1)
                    begin
                        state_next = ST_MEAN;
                    end
                    else
                    begin
                        var_next   = {dvd_reg[DEV_W-2:0], ~rem_sub[ACC_W]};
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MEAN:
            begin
                // apply the mean step, then multiply by |value - new mean|
                mean_next   = nm[VALUE_W-1:0];
                acc_next    = '0;
                mcand_next  = p_reg;
                mplier_next = mag2;
                step_next   = 7'(VALUE_W - 1);
                state_next  = ST_MUL2;
            end
            ST_DONE:
            begin
                if (!ovalid_reg || results.ready)
                begin
                    ovalid_next                      = 1'b1;
                    odata_next.sample_count          = cnt_reg;
                    odata_next.total_weight          = wgt_reg;
                    odata_next.running_mean          = mean_reg;
                    odata_next.squared_deviation_sum = dev_reg;
                    odata_next.variance              = var_reg;
                    odata_next.saturated             = ovf_reg;
                    state_next                       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            cnt_reg    <= '0;
            wgt_reg    <= '0;
            mean_reg   <= '0;
            dev_reg    <= '0;
            ovf_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            cnt_reg    <= cnt_next;
            wgt_reg    <= wgt_next;
            mean_reg   <= mean_next;
            dev_reg    <= dev_next;
            ovf_reg    <= ovf_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg    <= val_next;
        neg_reg    <= neg_next;
        p_reg      <= p_next;
        var_reg    <= var_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        odata_reg  <= odata_next;
    end

endmodule
`default_nettype wire

### tb/tb_stats_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tb_stats_pkg
// Bit-true predictor of the weighted running variance block.
// ---------------------------------------------------------------------------
package tb_stats_pkg;
    import wrv_pkg::*;

    localparam logic [ACC_W-1:0] ACC_LIMIT = {ACC_W{1'b1}};
    localparam logic [DEV_W-1:0] DEV_LIMIT = {DEV_W{1'b1}};

    typedef struct {
        logic [ACC_W-1:0]          count;
        logic [ACC_W-1:0]          weight;
        logic signed [VALUE_W-1:0] mean;
        logic [DEV_W-1:0]          dev_sum;
        logic                      sat;
    } stats_state_t;

    // Saturating add of an unsigned term onto an accumulator of width ACC_W.
    function automatic logic [ACC_W-1:0] add_acc(input logic [ACC_W-1:0] a,
                                                 input logic [VALUE_W-1:0] b,
                                                 inout logic sat);
        logic [ACC_W:0] s;
        s = {1'b0, a} + b;
        if (s[ACC_W])
        begin
            sat = 1'b1;
            return ACC_LIMIT;
        end
        return s[ACC_W-1:0];
    endfunction

    // Apply one word to the statistics and return the word it yields.
    function automatic wrv_out_t update_stats(inout stats_state_t st,
                                              input wrv_in_t w);
        wrv_out_t r;
        logic signed [63:0] v, d1, d2, nm;
        logic [63:0] mag1, mag2, p, q;
        logic [127:0] prod;
        logic [DEV_W:0] s;
        if (w.func == FUNC_CLEAR)
        begin
            st.count = '0;
            st.weight = '0;
            st.mean = '0;
            st.dev_sum = '0;
            st.sat = 1'b0;
        end
        else
        begin
            st.count = add_acc(st.count, w.count_increment, st.sat);
            st.weight = add_acc(st.weight, w.sample_weight, st.sat);
            if (st.weight != 0)
            begin
                v = w.value;
                d1 = v - 64'(st.mean);
                mag1 = d1[63] ? -d1 : d1;
                p = 64'(w.sample_weight) * mag1;
                q = p / 64'(st.weight);
                nm = d1[63] ? 64'(st.mean) - q : 64'(st.mean) + q;
                st.mean = nm[31:0];
                d2 = v - nm;
                mag2 = d2[63] ? -d2 : d2;
                prod = 128'(p) * 128'(mag2);
                if (prod[127:64] != 0)
                begin
                    st.sat = 1'b1;
                    prod = 128'(DEV_LIMIT);
                end
                s = {1'b0, st.dev_sum} + prod[63:0];
                if (s[DEV_W])
                begin
                    st.sat = 1'b1;
                    st.dev_sum = DEV_LIMIT;
                end
                else
                    st.dev_sum = s[DEV_W-1:0];
            end
        end
        r.sample_count = st.count;
        r.total_weight = st.weight;
        r.running_mean = st.mean;
        r.squared_deviation_sum = st.dev_sum;
        r.variance = (st.weight <= 1) ? '0 : st.dev_sum / 64'(st.weight);
        r.saturated = st.sat;
        return r;
    endfunction
endpackage
`default_nettype wire

### tb/tb.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for weighted_running_variance.
// Directed and random sample words go in over a valid/ready channel with
// random gaps; every result word is checked against an in-bench predictor.
// ---------------------------------------------------------------------------
module tb;
    import wrv_pkg::*;
    import tb_stats_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 400;

    logic clk;
    logic rst_n;

    wrv_in_if  samples();
    wrv_out_if results();

    weighted_running_variance dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples.sink),
        .results (results.source)
    );

    stats_state_t stats;
    wrv_out_t     expected_stats[$];
    int           mismatch_count;
    int           idle_cycles;
    bit           failed;
    bit           quiet_mode;
    int           hold_off_cycles;

    // Clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Receiver ready: random stalls, plus a long hold-off on request
    initial
    begin
        results.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles <= hold_off_cycles - 1;
                results.ready <= 1'b0;
            end
            else
                results.ready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 8);
        end
    end

    // Check each accepted result word
    always @(posedge clk)
    begin
        wrv_out_t exp_w;
        if (rst_n && results.valid && results.ready)
        begin
            if (expected_stats.size() == 0)
            begin
                failed = 1'b1;
                if (mismatch_count < 10)
                    $display("Unexpected result word %p", results.data);
                mismatch_count++;
            end
            else
            begin
                exp_w = expected_stats.pop_front();
                if (results.data !== exp_w)
                begin
                    failed = 1'b1;
                    if (mismatch_count < 10)
                        $display("Mismatch: expected %p actual %p", exp_w, results.data);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no acceptance
    always @(posedge clk)
    begin
        if ((samples.valid && samples.ready) || (results.valid && results.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Send one word, predicting its result at acceptance
    task automatic send_word(input wrv_in_t w);
        while (!quiet_mode && $urandom_range(99) < 8)
        begin
            samples.valid <= 1'b0;
            @(posedge clk);
        end
        samples.valid <= 1'b1;
        samples.data  <= w;
        @(posedge clk);
        while (!samples.ready)
            @(posedge clk);
        expected_stats.push_back(update_stats(stats, w));
    endtask

    task automatic push(input logic [31:0] v, input logic [31:0] wt,
                        input logic [31:0] inc);
        wrv_in_t w;
        w.func = FUNC_PUSH;
        w.value = v;
        w.sample_weight = wt;
        w.count_increment = inc;
        send_word(w);
    endtask

    task automatic clear_stats();
        wrv_in_t w;
        w.func = FUNC_CLEAR;
        w.value = $urandom;
        w.sample_weight = $urandom;
        w.count_increment = $urandom;
        send_word(w);
    endtask

    task automatic wait_drained();
        samples.valid <= 1'b0;
        while (expected_stats.size() != 0)
            @(posedge clk);
    endtask

    // Extremes, clear, zero weight, saturation of the squared deviation sum
    task automatic test_directed();
        push(32'h0001_0000, 0, 1);
        push(32'h7FFF_FFFF, 1, 1);
        push(32'h8000_0000, 1, 1);
        push(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push(32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
        push(32'h8000_0000, 32'hFFFF_FFFF, 1);
        clear_stats();
        push(32'hFFFF_0000, 3, 1);
        push(32'h0003_8000, 5, 1);
        push(32'h0002_0000, 0, 0);
        clear_stats();
        for (int i = 0; i < 8; i++)
            push(i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        clear_stats();
        push(32'h1234_5678, 1, 1);
    endtask

    // Long receiver hold-off while words keep coming
    task automatic test_backpressure();
        hold_off_cycles = 1500;
        for (int i = 0; i < 6; i++)
            push($urandom, $urandom_range(1, 100), 1);
        wait_drained();
    endtask

    // Random mix: mostly short runs of pushes with moderate weights
    task automatic test_random(input int n);
        int k;
        k = 0;
        while (k < n)
        begin
            quiet_mode = (k >= 600 && k < 800);
            case ($urandom_range(9))
                0: clear_stats();
                1: push($urandom, $urandom, $urandom);
                2: push($urandom, 0, $urandom_range(3));
                default: push($urandom_range(3) == 0 ? $urandom
                                                     : $urandom_range(32'h000A_0000),
                              $urandom_range(1, 64), 1);
            endcase
            k++;
        end
        quiet_mode = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        samples.valid = 1'b0;
        samples.data = '0;
        mismatch_count = 0;
        idle_cycles = 0;
        failed = 1'b0;
        quiet_mode = 1'b0;
        hold_off_cycles = 0;
        stats = '{default: '0};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        wait_drained();
        test_backpressure();
        test_random(2000);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!failed && expected_stats.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
